FILE: hdl/tcw_pkg.sv
// Package for the text console writer: screen defaults, cell constants, beat widths,
// operation codes, sequencer states and the command/result structs.
// No dependencies.
`timescale 1ns / 1ps

package tcw_pkg;

    // Default screen geometry
    localparam int SCREEN_WIDTH  = 80;
    localparam int SCREEN_HEIGHT = 25;

    // Cell and character constants
    localparam logic [15:0] BLANK_CELL   = 16'h0032;
    localparam logic [7:0]  NEWLINE_CODE = 8'd10;

    // Stream beat widths
    localparam int IN_TDATA_W  = 32;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 32;

    typedef enum logic [1:0] {
        OP_PUT        = 2'd0,
        OP_SET_CURSOR = 2'd1,
        OP_READ_CELL  = 2'd2
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SCROLL,
        S_PUT_ADDR,
        S_PUT_GO,
        S_FILL,
        S_READ_ADDR,
        S_READ_REQ,
        S_READ_DATA,
        S_RESP
    } t_state;

    // One input beat, last member in the lowest bits
    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] target_column;
        logic [7:0] target_line;
        logic [7:0] color;
        logic [7:0] char_code;
    } t_cmd;

    // One result beat, last member in the lowest bits
    typedef struct packed {
        logic        accepted;
        logic [15:0] cell_word;
        logic [6:0]  cursor_column;
        logic [4:0]  cursor_line;
    } t_result;

endpackage

FILE: hdl/text_console_writer.sv
// Text console writer: put-char, set-cursor and read-cell on a cell screen.
// Newline blanks the rest of the row; a put with the cursor past the last row first scrolls
// the screen up one row and clears the bottom row to 0x0000.
// One item at a time: next beat taken in the cycle after the result leaves the sequencer.
// Reset (sync, active low) clears the cursor and starts a sweep writing 0x0032
// to every cell, with s_axis_tready low until the sweep ends.
`timescale 1ns / 1ps

module text_console_writer #(
    parameter int SCREEN_WIDTH  = tcw_pkg::SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = tcw_pkg::SCREEN_HEIGHT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // char_code[7:0], color[15:8], target_line[23:16], target_column[31:24]
    input  logic [tcw_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,
    // operation[1:0]
    input  logic [tcw_pkg::IN_TUSER_W-1:0]    i_s_axis_tuser,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // cursor_line[4:0], cursor_column[11:5], cell_word[27:12], accepted[28]
    output logic [tcw_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata
);

    localparam int CELLS  = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int PAD_W  = tcw_pkg::OUT_TDATA_W - $bits(tcw_pkg::t_result);

    tcw_pkg::t_cmd                    w_cmd;
    tcw_pkg::t_result                 w_res;
    logic                             w_res_valid;
    logic                             w_res_ready;
    logic                             w_we;
    logic                             w_re;
    logic [ADDR_W-1:0]                w_waddr;
    logic [ADDR_W-1:0]                w_raddr;
    logic [15:0]                      w_wdata;
    logic [15:0]                      w_rdata;
    logic                             r_ovalid;
    logic [tcw_pkg::OUT_TDATA_W-1:0]  r_odata;

    // Unpack the input beat
    assign w_cmd = {i_s_axis_tuser, i_s_axis_tdata};

    tcw_ctrl #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (i_s_axis_tvalid),
        .o_cmd_ready (o_s_axis_tready),
        .i_cmd       (w_cmd),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready),
        .o_res       (w_res),
        .o_we        (w_we),
        .o_waddr     (w_waddr),
        .o_wdata     (w_wdata),
        .o_re        (w_re),
        .o_raddr     (w_raddr),
        .i_rdata     (w_rdata)
    );

    tcw_cell_ram #(
        .DEPTH (CELLS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Output register: take a new result when empty or being drained
    assign w_res_ready = !r_ovalid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_res_valid && w_res_ready) begin
            r_ovalid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid && w_res_ready) begin
            r_odata <= {{PAD_W{1'b0}}, w_res};
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;

endmodule

FILE: hdl/tcw_cell_ram.sv
// Cell memory of the text console writer: one write port, one read port,
// registered read data. No dependencies.
`timescale 1ns / 1ps

module tcw_cell_ram #(
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [15:0]              i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [15:0]              o_rdata
);

    logic [15:0] r_mem [DEPTH];
    logic [15:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, data registered
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/tcw_ctrl.sv
// Sequencer of the text console writer: cursor registers, command decode and
// the shared address/fill/copy engine that drives the cell memory.
// Depends on tcw_pkg.
`timescale 1ns / 1ps

module tcw_ctrl #(
    parameter int SCREEN_WIDTH  = tcw_pkg::SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = tcw_pkg::SCREEN_HEIGHT
) (
    input  logic                                           i_clk,
    input  logic                                           i_rst_n,
    input  logic                                           i_cmd_valid,
    output logic                                           o_cmd_ready,
    input  tcw_pkg::t_cmd                                  i_cmd,
    output logic                                           o_res_valid,
    input  logic                                           i_res_ready,
    output tcw_pkg::t_result                               o_res,
    output logic                                           o_we,
    output logic [$clog2(SCREEN_WIDTH*SCREEN_HEIGHT)-1:0]  o_waddr,
    output logic [15:0]                                    o_wdata,
    output logic                                           o_re,
    output logic [$clog2(SCREEN_WIDTH*SCREEN_HEIGHT)-1:0]  o_raddr,
    input  logic [15:0]                                    i_rdata
);

    localparam int CELLS  = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int CNT_W  = $clog2(CELLS + 1);
    localparam int ROW_W  = $clog2(SCREEN_HEIGHT + 1);
    localparam int COL_W  = $clog2(SCREEN_WIDTH);

    tcw_pkg::t_state    r_state, n_state;
    tcw_pkg::t_state    r_ret, n_ret;
    logic [ROW_W-1:0]   r_row, n_row;
    logic [COL_W-1:0]   r_col, n_col;
    logic [ADDR_W-1:0]  r_addr, n_addr;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               r_pend, n_pend;
    logic [15:0]        r_val, n_val;
    tcw_pkg::t_cmd      r_cmd, n_cmd;
    logic [ADDR_W-1:0]  r_src, n_src;
    logic [15:0]        r_word, n_word;
    logic               r_ok, n_ok;
    logic               w_row_ok;
    logic               w_col_ok;
    logic               w_line_in;

    // Control registers; reset starts the clearing sweep over every cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tcw_pkg::S_FILL;
            r_ret   <= tcw_pkg::S_IDLE;
            r_row   <= '0;
            r_col   <= '0;
            r_addr  <= '0;
            r_cnt   <= CNT_W'(CELLS);
            r_pend  <= 1'b0;
            r_val   <= tcw_pkg::BLANK_CELL;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_row   <= n_row;
            r_col   <= n_col;
            r_addr  <= n_addr;
            r_cnt   <= n_cnt;
            r_pend  <= n_pend;
            r_val   <= n_val;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_src  <= n_src;
        r_word <= n_word;
        r_ok   <= n_ok;
    end

    // Range checks on the held command
    assign w_row_ok  = 32'(r_cmd.target_line) <= 32'(SCREEN_HEIGHT);
    assign w_col_ok  = 32'(r_cmd.target_column) < 32'(SCREEN_WIDTH);
    assign w_line_in = 32'(r_cmd.target_line) < 32'(SCREEN_HEIGHT);

    // Memory ports: copy writes take the read data, all else the fill value
    assign o_waddr = r_addr;
    assign o_raddr = r_src;
    assign o_wdata = (r_state == tcw_pkg::S_SCROLL) ? i_rdata : r_val;

    // Result fields
    assign o_res.cursor_line   = 5'(r_row);
    assign o_res.cursor_column = 7'(r_col);
    assign o_res.cell_word     = r_word;
    assign o_res.accepted      = r_ok;

    // Next state and outputs
    always_comb begin
        n_state     = r_state;
        n_ret       = r_ret;
        n_row       = r_row;
        n_col       = r_col;
        n_addr      = r_addr;
        n_cnt       = r_cnt;
        n_pend      = 1'b0;
        n_val       = r_val;
        n_cmd       = r_cmd;
        n_src       = r_src;
        n_word      = r_word;
        n_ok        = r_ok;
        o_cmd_ready = 1'b0;
        o_res_valid = 1'b0;
        o_we        = 1'b0;
        o_re        = 1'b0;

        case (r_state)
            tcw_pkg::S_IDLE: begin
                o_cmd_ready = 1'b1;
                if (i_cmd_valid) begin
                    n_cmd   = i_cmd;
                    n_word  = '0;
                    n_ok    = 1'b0;
                    n_state = tcw_pkg::S_DECODE;
                end
            end

            tcw_pkg::S_DECODE: begin
                case (r_cmd.operation)
                    tcw_pkg::OP_PUT: begin
                        // Cursor past the last row: scroll first
                        if (32'(r_row) >= 32'(SCREEN_HEIGHT)) begin
                            n_src   = ADDR_W'(SCREEN_WIDTH);
                            n_addr  = '0;
                            n_cnt   = CNT_W'(CELLS - SCREEN_WIDTH);
                            n_state = tcw_pkg::S_SCROLL;
                        end else begin
                            n_state = tcw_pkg::S_PUT_ADDR;
                        end
                    end
                    tcw_pkg::OP_SET_CURSOR: begin
                        if (w_row_ok) begin
                            n_row = ROW_W'(r_cmd.target_line);
                        end
                        if (w_col_ok) begin
                            n_col = COL_W'(r_cmd.target_column);
                        end
                        n_ok    = w_row_ok && w_col_ok;
                        n_state = tcw_pkg::S_RESP;
                    end
                    tcw_pkg::OP_READ_CELL: begin
                        if (w_line_in && w_col_ok) begin
                            n_state = tcw_pkg::S_READ_ADDR;
                        end else begin
                            n_state = tcw_pkg::S_RESP;
                        end
                    end
                    default: begin
                        n_state = tcw_pkg::S_RESP;
                    end
                endcase
            end

            tcw_pkg::S_SCROLL: begin
                // Issue one read per cycle, write each word one row up as its read data returns
                if (r_cnt != '0) begin
                    o_re   = 1'b1;
                    n_src  = r_src + 1'b1;
                    n_cnt  = r_cnt - 1'b1;
                    n_pend = 1'b1;
                end
                if (r_pend) begin
                    o_we   = 1'b1;
                    n_addr = r_addr + 1'b1;
                end
                // Copy drained: clear the bottom row, park cursor on it
                if (r_cnt == '0 && !r_pend) begin
                    n_addr  = ADDR_W'((SCREEN_HEIGHT - 1) * SCREEN_WIDTH);
                    n_cnt   = CNT_W'(SCREEN_WIDTH);
                    n_val   = '0;
                    n_row   = ROW_W'(SCREEN_HEIGHT - 1);
                    n_col   = '0;
                    n_ret   = tcw_pkg::S_PUT_ADDR;
                    n_state = tcw_pkg::S_FILL;
                end
            end

            tcw_pkg::S_PUT_ADDR: begin
                n_addr  = ADDR_W'(32'(r_row) * 32'(SCREEN_WIDTH) + 32'(r_col));
                n_state = tcw_pkg::S_PUT_GO;
            end

            tcw_pkg::S_PUT_GO: begin
                if (r_cmd.char_code == tcw_pkg::NEWLINE_CODE) begin
                    // Blank out the rest of the row
                    n_cnt = CNT_W'(32'(SCREEN_WIDTH) - 32'(r_col));
                    n_val = tcw_pkg::BLANK_CELL;
                    n_row = r_row + 1'b1;
                    n_col = '0;
                end else begin
                    n_cnt = CNT_W'(1);
                    n_val = {r_cmd.color, r_cmd.char_code};
                    if (32'(r_col) == 32'(SCREEN_WIDTH - 1)) begin
                        n_col = '0;
                        n_row = r_row + 1'b1;
                    end else begin
                        n_col = r_col + 1'b1;
                    end
                end
                n_ret   = tcw_pkg::S_RESP;
                n_state = tcw_pkg::S_FILL;
            end

            tcw_pkg::S_FILL: begin
                // Write one cell per cycle until the count runs out
                o_we   = 1'b1;
                n_addr = r_addr + 1'b1;
                n_cnt  = r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    n_state = r_ret;
                end
            end

            tcw_pkg::S_READ_ADDR: begin
                n_src = ADDR_W'(32'(r_cmd.target_line) * 32'(SCREEN_WIDTH)
                                + 32'(r_cmd.target_column));
                n_state = tcw_pkg::S_READ_REQ;
            end

            tcw_pkg::S_READ_REQ: begin
                o_re    = 1'b1;
                n_state = tcw_pkg::S_READ_DATA;
            end

            tcw_pkg::S_READ_DATA: begin
                n_word  = i_rdata;
                n_state = tcw_pkg::S_RESP;
            end

            tcw_pkg::S_RESP: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = tcw_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = tcw_pkg::S_IDLE;
            end
        endcase
    end

endmodule

FILE: hdl/tcw_checker.sv
// Port-level checker for the text console writer, bound to the top level.
// Depends on tcw_pkg and text_console_writer.
`timescale 1ns / 1ps

module tcw_checker #(
    parameter int SCREEN_WIDTH  = tcw_pkg::SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = tcw_pkg::SCREEN_HEIGHT
) (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_s_axis_tvalid,
    input logic                              o_s_axis_tready,
    input logic                              o_m_axis_tvalid,
    input logic                              i_m_axis_tready,
    input logic [tcw_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata
);

    // Stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("result beat changed while stalled");

    // Reset starts the clearing sweep: no input taken, no result shown
    a_reset_busy: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_s_axis_tready && !o_m_axis_tvalid)
        else $error("block not busy right after reset");

    // No input beat is taken in the cycle after one is accepted
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("input taken on consecutive cycles");

    // Accepted set-cursor carries no cell word
    a_flag_no_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[28] |-> o_m_axis_tdata[27:12] == 16'd0)
        else $error("cell word with accepted flag");

    // Cursor stays on screen, or on the row just past the end
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            ((SCREEN_WIDTH > 127) || (32'(o_m_axis_tdata[11:5]) < 32'(SCREEN_WIDTH))) &&
            ((SCREEN_HEIGHT > 31) || (32'(o_m_axis_tdata[4:0]) <= 32'(SCREEN_HEIGHT))))
        else $error("cursor off screen");

endmodule

bind text_console_writer tcw_checker #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
) u_tcw_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
